[design/u16u8_pkg.sv]
package u16u8_pkg;

  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned MaxBytes = 6;

  localparam logic [15:0] CapReset = 16'd255;
  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast = 16'hDBFF;
  localparam logic [15:0] LowFirst = 16'hDC00;
  localparam logic [15:0] LowLast = 16'hDFFF;
  localparam logic [15:0] UnitNull = 16'h0000;
  localparam logic [15:0] UnitNone = 16'hFFFF;
  localparam logic [20:0] SuppBase = 21'h10000;
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;
  localparam logic [7:0] ContMask = 8'h3F;

  localparam logic [2:0] RegAddrCap = 3'd0;

  typedef struct packed {
    logic [2:0] n;
    logic [3:0][7:0] b;
  } enc_t;

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e.b = '0;
    if (cp < 21'h80) begin
      e.n = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n = 3'd2;
      e.b[0] = Lead2 | {3'b000, cp[10:6]};
      e.b[1] = ContMark | (cp[7:0] & ContMask);
    end else if (cp < SuppBase) begin
      e.n = 3'd3;
      e.b[0] = Lead3 | {4'b0000, cp[15:12]};
      e.b[1] = ContMark | ({2'b00, cp[11:6]} & ContMask);
      e.b[2] = ContMark | (cp[7:0] & ContMask);
    end else begin
      e.n = 3'd4;
      e.b[0] = Lead4 | {5'b00000, cp[20:18]};
      e.b[1] = ContMark | ({2'b00, cp[17:12]} & ContMask);
      e.b[2] = ContMark | ({2'b00, cp[11:6]} & ContMask);
      e.b[3] = ContMark | (cp[7:0] & ContMask);
    end
    return e;
  endfunction

endpackage

[design/utf16le_to_utf8_stream_top.sv]
// A unit's first UTF-8 byte is registered, offered in the cycle after its transfer.
// Throughput: one result byte per cycle while m_axis_tready is high; a unit's
// bytes (up to six) leave the output register one byte a cycle, and the next unit
// is taken only as the last of them goes; a unit that makes no byte loads only if last.
// Asynchronous active-low reset clears control state and sets out_capacity to 255.
module utf16le_to_utf8_stream_top #(
  parameter int unsigned COUNT_BITS = u16u8_pkg::CountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream: tdata[15:0] code_unit; tlast last_unit.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // Output stream: tdata[7:0] utf8_byte, [8] run_last, [24:9] byte_total, rest zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  // tuser[0] byte_valid.
  output logic        m_axis_tuser,
  // tlast string_done.
  output logic        m_axis_tlast
);
  import u16u8_pkg::*;

  localparam int unsigned CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int unsigned SW = CW + 1;

  logic [15:0] cap_q;
  logic [15:0] held_q, held_d;
  logic held_vld_q, held_vld_d;
  logic halted_q, halted_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic [MaxBytes-1:0][7:0] ob_q, ob_d;
  logic [2:0] on_q, on_d;
  logic [2:0] oi_q;
  logic oph_q, oph_d;
  logic olast_q;
  logic [COUNT_BITS-1:0] otot_q, otot_d;
  logic ovld_q;

  logic in_xfer, out_xfer, out_final, load;
  logic [15:0] w;
  logic last;
  logic is_high, is_low, term;
  logic [20:0] cp_a;
  enc_t enc_a, enc_b;
  logic [SW-1:0] cnt_ext, cap16_ext, cmax_ext, cap_ext, sum_a, sum_b;
  logic a_try, fit_a, a_emit, b_go, b_try, fit_b, b_emit, hold, halt_set;
  logic [2:0] na_eff, nb_eff, n_tot, k;

  assign pready = 1'b1;
  assign prdata = {16'd0, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (psel && penable && pwrite && pready && (paddr == RegAddrCap)) begin
      cap_q <= pwdata[15:0];
    end
  end

  assign w = s_axis_tdata;
  assign last = s_axis_tlast;
  assign is_high = (w >= HighFirst) && (w <= HighLast);
  assign is_low = (w >= LowFirst) && (w <= LowLast);
  assign term = (w == UnitNull) || (w == UnitNone);

  assign cp_a = (held_vld_q && is_low)
              ? (SuppBase + {1'b0, held_q[9:0], w[9:0]}) : {5'd0, held_q};
  assign enc_a = utf8_enc(cp_a);
  assign enc_b = utf8_enc({5'd0, w});

  assign cnt_ext = SW'(cnt_q);
  assign cap16_ext = SW'(cap_q);
  assign cmax_ext = SW'({COUNT_BITS{1'b1}});
  assign cap_ext = (cap16_ext > cmax_ext) ? cmax_ext : cap16_ext;

  assign a_try = !halted_q && held_vld_q;
  assign sum_a = cnt_ext + SW'(enc_a.n);
  assign fit_a = (sum_a <= cap_ext);
  assign a_emit = a_try && fit_a;
  assign na_eff = a_emit ? enc_a.n : 3'd0;

  assign b_go = !halted_q && (!held_vld_q || (!is_low && fit_a));
  assign hold = b_go && !term && is_high && !last;
  assign b_try = b_go && !term && !(is_high && !last);
  assign sum_b = cnt_ext + SW'(na_eff) + SW'(enc_b.n);
  assign fit_b = (sum_b <= cap_ext);
  assign b_emit = b_try && fit_b;
  assign nb_eff = b_emit ? enc_b.n : 3'd0;
  assign halt_set = (a_try && !fit_a) || (b_go && term) || (b_try && !fit_b);
  assign n_tot = na_eff + nb_eff;

  assign out_final = oph_q || (oi_q == (on_q - 3'd1));
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !ovld_q || (out_xfer && out_final);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign load = in_xfer && ((n_tot != 3'd0) || last);

  always_comb begin
    held_d = held_q;
    held_vld_d = held_vld_q;
    halted_d = halted_q;
    cnt_d = cnt_q;
    if (in_xfer) begin
      if (last) begin
        held_d = '0;
        held_vld_d = 1'b0;
        halted_d = 1'b0;
        cnt_d = '0;
      end else if (!halted_q) begin
        held_d = hold ? w : 16'd0;
        held_vld_d = hold;
        halted_d = halt_set;
        cnt_d = cnt_q + COUNT_BITS'(n_tot);
      end
    end
  end

  always_comb begin
    ob_d = '0;
    k = '0;
    for (int i = 0; i < MaxBytes; i++) begin
      k = 3'(i) - na_eff;
      if (3'(i) < na_eff) begin
        ob_d[i] = enc_a.b[i % 4];
      end else if (k < 3'd3) begin
        ob_d[i] = enc_b.b[k[1:0]];
      end
    end
    oph_d = (n_tot == 3'd0);
    on_d = oph_d ? 3'd1 : n_tot;
    otot_d = oph_d ? cnt_q : cnt_q + COUNT_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      held_vld_q <= 1'b0;
      halted_q <= 1'b0;
      cnt_q <= '0;
      ovld_q <= 1'b0;
      oi_q <= '0;
    end else begin
      held_q <= held_d;
      held_vld_q <= held_vld_d;
      halted_q <= halted_d;
      cnt_q <= cnt_d;
      if (load) begin
        ovld_q <= 1'b1;
        oi_q <= '0;
      end else if (out_xfer) begin
        if (out_final) begin
          ovld_q <= 1'b0;
        end
        oi_q <= oi_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_q <= ob_d;
      on_q <= on_d;
      oph_q <= oph_d;
      olast_q <= last;
      otot_q <= otot_d;
    end else if (out_xfer) begin
      otot_q <= otot_q + COUNT_BITS'(1);
    end
  end

  logic [CW-1:0] otot_ext;
  logic [7:0] obyte;

  assign otot_ext = CW'(otot_q);
  assign obyte = (oph_q || (oi_q >= 3'(MaxBytes))) ? 8'd0 : ob_q[oi_q];

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = {7'd0, otot_ext[15:0], out_final, obyte};
  assign m_axis_tuser = !oph_q;
  assign m_axis_tlast = olast_q && out_final;

endmodule
